@@ rtl/utx_pkg.sv @@
// Package for the serial transmitter with ring FIFO.
// Holds the queued command type, result type and frame phase codes; no dependencies.
package utx_pkg;

    localparam int DATA_BITS = 8;
    localparam int BIT_W     = $clog2(DATA_BITS);

    // Frame phase codes.
    localparam logic [1:0] PHASE_START = 2'd0;
    localparam logic [1:0] PHASE_DATA  = 2'd1;
    localparam logic [1:0] PHASE_STOP  = 2'd2;

    // Operation codes of an input request.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // A classified request as it waits between the front and the engine.
    typedef struct packed {
        logic                 is_tick;
        logic [DATA_BITS-1:0] data_byte;
    } t_cmd;

    // One result.
    typedef struct packed {
        logic accepted;
        logic txd_level;
        logic fifo_empty;
        logic ticker_running;
    } t_res;

endpackage

@@ rtl/utx_if.sv @@
// Valid/ready channel interfaces for the request and result sides.
// Depends on nothing; used by the front, the engine and the top level.
interface utx_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_byte;
    logic       end_of_write;

    modport source (output valid, output operation, output data_byte,
                    output end_of_write, input ready);
    modport sink   (input valid, input operation, input data_byte,
                    input end_of_write, output ready);
endinterface

interface utx_out_if;
    logic valid;
    logic ready;
    logic accepted;
    logic txd_level;
    logic fifo_empty;
    logic ticker_running;

    modport source (output valid, output accepted, output txd_level,
                    output fifo_empty, output ticker_running, input ready);
    modport sink   (input valid, input accepted, input txd_level,
                    input fifo_empty, input ticker_running, output ready);
endinterface

@@ rtl/utx_front.sv @@
// Front end: accepts requests, classifies them and holds them in a two-entry queue.
// Depends on utx_pkg and utx_in_if.
module utx_front
    import utx_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    utx_in_if.sink     i_in,
    output t_cmd       o_cmd,
    output logic       o_cmd_valid,
    input  logic       i_cmd_pop
);

    t_cmd       r_q [2];
    logic       r_wr_idx;
    logic       r_rd_idx;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       push;
    t_cmd       cmd_in;

    assign i_in.ready  = (r_count != 2'd2);
    assign push        = i_in.valid && i_in.ready;
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd_idx];

    always_comb begin
        cmd_in.is_tick   = (i_in.operation == OP_TICK);
        cmd_in.data_byte = i_in.data_byte;
    end

    always_comb begin
        n_count = r_count;
        if (push && !i_cmd_pop) begin
            n_count = r_count + 2'd1;
        end else if (!push && i_cmd_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= 1'b0;
            r_rd_idx <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_idx <= ~r_wr_idx;
            end
            if (i_cmd_pop) begin
                r_rd_idx <= ~r_rd_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_idx] <= cmd_in;
        end
    end

endmodule

@@ rtl/utx_engine.sv @@
// Back end: byte FIFO memory, pointers, 8N1 frame sequencer and result register.
// Depends on utx_pkg and utx_out_if.
module utx_engine
    import utx_pkg::*;
#(
    parameter int FIFO_DEPTH = 1024
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic       i_cmd_valid,
    output logic       o_cmd_pop,
    utx_out_if.source  o_out
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] res;
        if (p == PTR_W'(FIFO_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = p + PTR_W'(1);
        end
        return res;
    endfunction

    logic [DATA_BITS-1:0] r_mem [FIFO_DEPTH];
    logic [DATA_BITS-1:0] r_rdata;

    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [1:0]       r_phase, n_phase;
    logic [BIT_W-1:0] r_bit_pos, n_bit_pos;
    logic             r_running, n_running;
    logic             r_line, n_line;
    logic             r_out_valid;
    t_res             r_out, n_out;

    logic             advance;
    logic             mem_we;
    logic [PTR_W-1:0] wr_next;

    assign advance   = i_cmd_valid && (!r_out_valid || o_out.ready);
    assign o_cmd_pop = advance;
    assign wr_next   = ptr_next(r_wr_ptr);

    always_comb begin
        n_rd_ptr  = r_rd_ptr;
        n_wr_ptr  = r_wr_ptr;
        n_phase   = r_phase;
        n_bit_pos = r_bit_pos;
        n_running = r_running;
        n_line    = r_line;
        mem_we    = 1'b0;
        n_out.accepted = 1'b0;
        if (!i_cmd.is_tick) begin
            if (wr_next != r_rd_ptr) begin
                mem_we         = 1'b1;
                n_wr_ptr       = wr_next;
                n_running      = 1'b1;
                n_out.accepted = 1'b1;
            end
        end else if (r_running) begin
            case (r_phase)
                PHASE_DATA: begin
                    n_line = r_rdata[r_bit_pos];
                    if (r_bit_pos == BIT_W'(DATA_BITS - 1)) begin
                        n_bit_pos = '0;
                        n_phase   = PHASE_STOP;
                    end else begin
                        n_bit_pos = r_bit_pos + BIT_W'(1);
                    end
                end
                PHASE_STOP: begin
                    n_line   = 1'b1;
                    n_phase  = PHASE_START;
                    n_rd_ptr = ptr_next(r_rd_ptr);
                end
                default: begin
                    n_line    = 1'b0;
                    n_phase   = PHASE_DATA;
                    n_bit_pos = '0;
                end
            endcase
            n_running = (n_rd_ptr != r_wr_ptr);
        end
        n_out.txd_level      = n_line;
        n_out.fifo_empty     = (n_rd_ptr == n_wr_ptr);
        n_out.ticker_running = n_running;
    end

    // The head byte is read every cycle; it is stable for the whole frame.
    always_ff @(posedge i_clk) begin
        if (advance && mem_we) begin
            r_mem[r_wr_ptr] <= i_cmd.data_byte;
        end
        r_rdata <= r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_phase     <= PHASE_START;
            r_bit_pos   <= '0;
            r_running   <= 1'b0;
            r_line      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_rd_ptr  <= n_rd_ptr;
                r_wr_ptr  <= n_wr_ptr;
                r_phase   <= n_phase;
                r_bit_pos <= n_bit_pos;
                r_running <= n_running;
                r_line    <= n_line;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.accepted       = r_out.accepted;
    assign o_out.txd_level      = r_out.txd_level;
    assign o_out.fifo_empty     = r_out.fifo_empty;
    assign o_out.ticker_running = r_out.ticker_running;

endmodule

@@ rtl/uart_tx_fifo_serializer_unit.sv @@
// A request accepted by the front waits in its queue until the engine registers its result.
// Throughput: one request per cycle unless a waiting result stalls the engine.
// The front queue holds two requests, so a waiting result closes the input only once
// two requests have backed up behind it.
// Reset: synchronous, active low; clears pointers, frame state, queue and result valid.
// The byte memory is not cleared; only entries already written are ever sent.
module uart_tx_fifo_serializer_unit
    import utx_pkg::*;
#(
    parameter int FIFO_DEPTH = 1024
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    utx_in_if.sink    i_in,
    utx_out_if.source o_out
);

    // Classified requests pass from the front to the engine through this handshake.
    t_cmd cmd;
    logic cmd_valid;
    logic cmd_pop;

    // The front accepts a request whenever its queue has room and sorts it into
    // a byte write or a bit tick.
    utx_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    // The engine owns the byte memory and the frame sequencer. It takes one
    // request a cycle whenever its result register is free or being emptied.
    utx_engine #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .o_out       (o_out)
    );

`ifndef SYNTHESIS
    // The engine never takes a request from an empty queue.
    a_pop_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> cmd_valid)
        else $error("request popped from empty queue");

    // The ticker runs exactly while the FIFO holds bytes.
    a_running_matches_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.ticker_running == !o_out.fifo_empty))
        else $error("ticker state disagrees with FIFO fill");

    // A byte that was just queued cannot leave the FIFO empty.
    a_accept_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.accepted) |-> !o_out.fifo_empty)
        else $error("FIFO empty after accepted write");
`endif

endmodule

@@ tb/uart_tx_fifo_serializer_unit_tb.sv @@
// Self-checking testbench for the 8N1 serial transmitter with its ring FIFO.
// Depends on utx_pkg, the utx_in_if/utx_out_if interfaces and the top level of the block.
module uart_tx_fifo_serializer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import utx_pkg::*;

    localparam int FIFO_DEPTH     = 1024;
    localparam int WATCHDOG_LIMIT = 3000;
    // The receiver's long hold-off starts once this many requests have been taken,
    // which falls inside the burst that fills the FIFO.
    localparam int HOLD_AT        = 400;
    localparam int HOLD_CYCLES    = 300;
    // Number of requests taken before the pacing of both sides moves on.
    localparam int PACE_SPAN      = 160;

    // Pacing of the two channels; the phases follow one another in this order.
    typedef enum logic [1:0] {
        PACE_FREE,
        PACE_SENDER_IDLE,
        PACE_RECEIVER_STALL,
        PACE_BOTH
    } t_pace;

    // One request as the testbench holds it before it is offered.
    typedef struct {
        logic       op;
        logic [7:0] data;
        logic       eow;
    } t_request;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    utx_in_if  in_if ();
    utx_out_if out_if ();

    uart_tx_fifo_serializer_unit #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Requests still to be offered, and the line results owed for requests taken.
    t_request requests_waiting[$];
    t_res     line_results_due[$];

    int n_requests_taken = 0;
    int mismatches       = 0;
    int hold_left        = 0;
    bit hold_done        = 1'b0;

    // The testbench's own image of the transmitter: the byte store, both
    // pointers, the frame position, the ticker and the level on the line.
    logic [7:0]  fifo_bytes [FIFO_DEPTH];
    int unsigned rd_slot;
    int unsigned wr_slot;
    logic [1:0]  frame_phase;
    logic [2:0]  data_bit;
    logic        ticking;
    logic        line_now;

    function automatic int unsigned next_slot(int unsigned slot);
        return (slot + 1 >= FIFO_DEPTH) ? 0 : slot + 1;
    endfunction

    // Applies one taken request to the image and returns the line result it causes.
    function automatic t_res advance_transmitter(t_request req);
        t_res res;
        int unsigned after_wr;
        res.accepted = 1'b0;
        if (req.op == OP_WRITE) begin
            after_wr = next_slot(wr_slot);
            // A write into a FIFO already holding depth minus one bytes is dropped.
            if (after_wr != rd_slot) begin
                fifo_bytes[wr_slot] = req.data;
                wr_slot             = after_wr;
                res.accepted        = 1'b1;
                ticking             = 1'b1;
            end
        end else if (ticking) begin
            // A tick only counts while the ticker runs; otherwise it changes nothing.
            case (frame_phase)
                PHASE_DATA: begin
                    line_now = fifo_bytes[rd_slot][data_bit];
                    if (data_bit == 3'(DATA_BITS - 1)) begin
                        data_bit    = '0;
                        frame_phase = PHASE_STOP;
                    end else begin
                        data_bit = data_bit + 3'd1;
                    end
                end
                PHASE_STOP: begin
                    // The stop bit frees the byte that has just gone out.
                    line_now    = 1'b1;
                    frame_phase = PHASE_START;
                    rd_slot     = next_slot(rd_slot);
                end
                default: begin
                    // The spare phase code behaves as a start bit.
                    line_now    = 1'b0;
                    frame_phase = PHASE_DATA;
                    data_bit    = '0;
                end
            endcase
            ticking = (rd_slot != wr_slot);
        end
        res.txd_level      = line_now;
        res.fifo_empty     = (rd_slot == wr_slot);
        res.ticker_running = ticking;
        return res;
    endfunction

    function automatic t_pace pace_now();
        return t_pace'((n_requests_taken / PACE_SPAN) % 4);
    endfunction

    function automatic void compare_field(string name, logic want, logic got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %b, actual %b", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic queue_request(logic op, logic [7:0] data, logic eow);
        t_request req;
        req.op   = op;
        req.data = data;
        req.eow  = eow;
        requests_waiting.push_back(req);
    endtask

    task automatic queue_tick();
        queue_request(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // Request driver. A request stays on the channel until it is taken; only
    // then may the sender rest, so valid is never dropped under a waiting request.
    always @(posedge i_clk) begin : request_driver
        t_request nxt;
        bit       rest;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_if.ready) begin
            if (in_if.valid) begin
                nxt.op   = in_if.operation;
                nxt.data = in_if.data_byte;
                nxt.eow  = in_if.end_of_write;
                line_results_due.push_back(advance_transmitter(nxt));
                n_requests_taken <= n_requests_taken + 1;
            end
            case (pace_now())
                PACE_SENDER_IDLE: rest = ($urandom_range(0, 99) < 64);
                PACE_BOTH:        rest = ($urandom_range(0, 99) < 29);
                default:          rest = 1'b0;
            endcase
            if (requests_waiting.size() != 0 && !rest) begin
                nxt                 = requests_waiting.pop_front();
                in_if.valid        <= 1'b1;
                in_if.operation    <= nxt.op;
                in_if.data_byte    <= nxt.data;
                in_if.end_of_write <= nxt.eow;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // One long hold-off of the receiver, so that the result side backs up,
    // the block's queue fills and its request side has to close.
    always @(posedge i_clk) begin : receiver_hold
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_requests_taken >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Result monitor: each result taken is compared with the oldest one owed.
    always @(posedge i_clk) begin : result_monitor
        t_res due;
        bit   stall;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (line_results_due.size() == 0) begin
                    $display("%0t: result with no request outstanding, actual %b%b%b%b",
                             $time, out_if.accepted, out_if.txd_level,
                             out_if.fifo_empty, out_if.ticker_running);
                    mismatches++;
                end else begin
                    due = line_results_due.pop_front();
                    compare_field("accepted", due.accepted, out_if.accepted);
                    compare_field("txd_level", due.txd_level, out_if.txd_level);
                    compare_field("fifo_empty", due.fifo_empty, out_if.fifo_empty);
                    compare_field("ticker_running", due.ticker_running,
                                  out_if.ticker_running);
                end
            end
            case (pace_now())
                PACE_RECEIVER_STALL: stall = ($urandom_range(0, 99) < 64);
                PACE_BOTH:           stall = ($urandom_range(0, 99) < 29);
                default:             stall = 1'b0;
            endcase
            out_if.ready <= (hold_left == 0) && !stall;
        end
    end

    // Watchdog: ends the run when neither side has moved a request for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        int bits_owed;
        int counted;
        int burst;
        int ticks;
        int roll;

        in_if.valid        = 1'b0;
        in_if.operation    = OP_WRITE;
        in_if.data_byte    = '0;
        in_if.end_of_write = 1'b0;
        out_if.ready       = 1'b0;

        rd_slot     = 0;
        wr_slot     = 0;
        frame_phase = PHASE_START;
        data_bit    = '0;
        ticking     = 1'b0;
        line_now    = 1'b1;

        // Directed opening: a tick with the ticker stopped, the two extreme bytes
        // sent back to back as full frames, then one more tick once it has stopped.
        queue_tick();
        queue_request(OP_WRITE, 8'h00, 1'b0);
        queue_request(OP_WRITE, 8'hFF, 1'b1);
        for (int k = 0; k < 20; k++)
            queue_tick();
        queue_tick();

        // Random well-formed writes: a burst of bytes ending a software write,
        // then mostly exactly the ticks needed to send them. Some bursts are cut
        // short or overrun, and a few lone requests are mixed in as noise.
        // bits_owed tracks the ticks the ticker will still honour.
        bits_owed = 0;
        counted   = 0;
        while (counted < 150) begin
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1) == 1) begin
                    queue_tick();
                    if (bits_owed > 0) begin
                        bits_owed--;
                        counted++;
                    end
                end else begin
                    queue_request(OP_WRITE, 8'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)));
                    bits_owed += 10;
                    counted++;
                end
            end else begin
                burst = $urandom_range(1, 8);
                for (int k = 0; k < burst; k++)
                    queue_request(OP_WRITE, 8'($urandom_range(0, 255)), k == burst - 1);
                bits_owed += 10 * burst;
                counted   += burst;
                roll = $urandom_range(0, 9);
                if (roll < 7)
                    ticks = bits_owed;
                else if (roll < 9)
                    ticks = $urandom_range(0, bits_owed);
                else
                    ticks = bits_owed + $urandom_range(1, 3);
                for (int k = 0; k < ticks; k++) begin
                    queue_tick();
                    if (bits_owed > 0) begin
                        bits_owed--;
                        counted++;
                    end
                end
            end
        end

        // Send what is left, then write without ticking until the FIFO is full
        // and a handful of bytes have been refused. The pointers no longer start
        // at zero, so the write pointer wraps on the way.
        for (int k = 0; k < bits_owed; k++)
            queue_tick();
        for (int k = 0; k < FIFO_DEPTH + 6; k++)
            queue_request(OP_WRITE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

        // With the FIFO nearly full, mostly ticks: each freed slot lets the
        // next write in, while other writes meet a full FIFO.
        for (int k = 0; k < 200; k++) begin
            if ($urandom_range(0, 99) < 85)
                queue_tick();
            else
                queue_request(OP_WRITE, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (requests_waiting.size() != 0 || in_if.valid)
            @(posedge i_clk);
        while (line_results_due.size() != 0)
            @(posedge i_clk);
        // Keep running a while longer, so that any stray result would still be seen.
        repeat (4) @(posedge i_clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
